// ===== hdl/aabe_pkg.sv =====
// Shared types, constants and arithmetic for the analog axis button event block.
`default_nettype none

package aabe_pkg;

	localparam int unsigned LEVEL_W = 10;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 16;

	localparam logic [LEVEL_W-1:0] RST_UPPER  = 10'd700;
	localparam logic [LEVEL_W-1:0] RST_LOWER  = 10'd300;
	localparam logic [LEVEL_W-1:0] RST_REST   = 10'd512;
	localparam logic [MS_W-1:0]    RST_FIRST  = 16'd500;
	localparam logic [MS_W-1:0]    RST_REPEAT = 16'd100;

	// ceil(2^19 / 10): exact quotient for every dividend below 2^14
	localparam logic [15:0] RECIP_10 = 16'd52429;

	typedef enum logic [KIND_W-1:0] {
		EV_UP_PRESS   = 3'd0,
		EV_UP_HOLD    = 3'd1,
		EV_UP_RELEASE = 3'd2,
		EV_DN_PRESS   = 3'd3,
		EV_DN_HOLD    = 3'd4,
		EV_DN_RELEASE = 3'd5
	} ev_kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_UPPER  = 3'd0,
		REG_LOWER  = 3'd1,
		REG_REST   = 3'd2,
		REG_FIRST  = 3'd3,
		REG_REPEAT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] upper;
		logic [LEVEL_W-1:0] lower;
		logic [MS_W-1:0]    first_hold;
		logic [MS_W-1:0]    repeat_hold;
	} cfg_t;

	// (9*old + sample) / 10, truncated, by reciprocal multiplication
	function automatic logic [LEVEL_W-1:0] filter_next(
		input logic [LEVEL_W-1:0] old,
		input logic [LEVEL_W-1:0] sample
	);
		logic [13:0] acc;
		logic [29:0] prod;
		acc  = {1'b0, old, 3'b000} + {4'b0000, old} + {4'b0000, sample};
		prod = {16'd0, acc} * {14'd0, RECIP_10};
		return prod[28:19];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/aabe_cfg_regs.sv =====
// Configuration register file holding thresholds and hold timings.
`default_nettype none

module aabe_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [aabe_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [aabe_pkg::DATA_W-1:0] cfg_data,
	output aabe_pkg::cfg_t                  cfg
);
	import aabe_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper       <= RST_UPPER;
			cfg_q.lower       <= RST_LOWER;
			cfg_q.first_hold  <= RST_FIRST;
			cfg_q.repeat_hold <= RST_REPEAT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UPPER:  cfg_q.upper       <= cfg_data[LEVEL_W-1:0];
				REG_LOWER:  cfg_q.lower       <= cfg_data[LEVEL_W-1:0];
				REG_FIRST:  cfg_q.first_hold  <= cfg_data[MS_W-1:0];
				REG_REPEAT: cfg_q.repeat_hold <= cfg_data[MS_W-1:0];
				// the filter preset lives with the filter itself
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/analog_axis_button_events.sv =====
// Top level: joystick axis filter with up/down press, hold-repeat and release events.
`default_nettype none

// One axis sample with its millisecond time enters per transaction and the
// block takes a new one in every cycle unless in_stall holds it. Each sample
// passes an input register, then the logic (divide-by-ten filter, threshold
// compares, 32-bit elapsed-time compare) that updates the filter and button
// state and loads the result register, from which an event is presented.
// Samples that cause no event produce no output transaction. Input stall rises
// only while a sample waits in the input register and the result register is
// full and stalled. Writing rest_level also presets the filter at once.
module analog_axis_button_events (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [2:0]                  cfg_index,
	input  wire logic [15:0]                 cfg_data,
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire logic [9:0]                  sample,
	input  wire logic [31:0]                 now_ms,
	output      logic                        out_valid,
	input  wire logic                        out_stall,
	output      logic [2:0]                  event_kind,
	output      logic [9:0]                  smoothed_level
);
	import aabe_pkg::*;

	cfg_t cfg;

	aabe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	logic                s1_valid_s1;
	logic [LEVEL_W-1:0]  sample_s1;
	logic [TIME_W-1:0]   now_s1;

	// button state
	logic [LEVEL_W-1:0]  filter_q;
	logic                engaged_q;
	logic                up_held_q;
	logic                down_held_q;
	logic [TIME_W-1:0]   last_event_q;
	logic                in_repeat_q;

	// result register
	logic                out_valid_q;
	ev_kind_t            kind_q;
	logic [LEVEL_W-1:0]  level_q;

	logic                res_free;
	logic                fire;
	logic                accept;

	logic [LEVEL_W-1:0]  level;
	logic                in_band;
	logic [TIME_W-1:0]   elapsed;
	logic [TIME_W-1:0]   interval;
	logic                emit;
	ev_kind_t            kind;
	logic                do_release;
	logic                do_press_up;
	logic                do_press_dn;
	logic                do_hold;

	assign res_free = !out_valid_q || !out_stall;
	assign fire     = s1_valid_s1 && res_free;
	assign in_stall = s1_valid_s1 && !res_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (fire) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			now_s1    <= now_ms;
		end
	end

	always_comb begin
		level    = filter_next(filter_q, sample_s1);
		in_band  = (level > cfg.lower) && (level < cfg.upper);
		elapsed  = now_s1 - last_event_q;
		interval = in_repeat_q ? {16'd0, cfg.repeat_hold} : {16'd0, cfg.first_hold};

		do_release  = 1'b0;
		do_press_up = 1'b0;
		do_press_dn = 1'b0;
		do_hold     = 1'b0;
		priority if (in_band) begin
			do_release = 1'b1;
		end else if (!engaged_q) begin
			do_press_up = level > cfg.upper;
			do_press_dn = !(level > cfg.upper) && (level < cfg.lower);
		end else begin
			do_hold = (up_held_q || down_held_q) && (elapsed >= interval);
		end
	end

	always_comb begin
		emit = 1'b0;
		kind = EV_UP_PRESS;
		priority if (do_release) begin
			emit = engaged_q && (up_held_q || down_held_q);
			kind = up_held_q ? EV_UP_RELEASE : EV_DN_RELEASE;
		end else if (do_press_up) begin
			emit = 1'b1;
			kind = EV_UP_PRESS;
		end else if (do_press_dn) begin
			emit = 1'b1;
			kind = EV_DN_PRESS;
		end else if (do_hold) begin
			emit = 1'b1;
			kind = up_held_q ? EV_UP_HOLD : EV_DN_HOLD;
		end else begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q     <= RST_REST;
			engaged_q    <= 1'b0;
			up_held_q    <= 1'b0;
			down_held_q  <= 1'b0;
			last_event_q <= '0;
			in_repeat_q  <= 1'b0;
		end else if (cfg_we && (cfg_index == REG_REST)) begin
			// preset the filter; the user must change config only while idle, not enforced here
			filter_q <= cfg_data[LEVEL_W-1:0];
		end else if (fire) begin
			filter_q <= level;
			if (do_release) begin
				engaged_q   <= 1'b0;
				up_held_q   <= 1'b0;
				down_held_q <= 1'b0;
			end else if (do_press_up || do_press_dn) begin
				engaged_q    <= 1'b1;
				up_held_q    <= do_press_up;
				down_held_q  <= do_press_dn;
				last_event_q <= now_s1;
				in_repeat_q  <= 1'b0;
			end else if (do_hold) begin
				last_event_q <= now_s1;
				in_repeat_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q  <= kind;
			level_q <= level;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_kind     = kind_q;
	assign smoothed_level = level_q;

`ifndef SYNTHESIS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(up_held_q && down_held_q))
		else $error("up and down held together");

	a_held_engaged: assert property (@(posedge clk) disable iff (!arst_n)
		(up_held_q || down_held_q) |-> engaged_q)
		else $error("side held while not engaged");

	a_emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit) |=> out_valid)
		else $error("emitted event not presented");

	a_hold_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && do_hold && !(cfg_we && (cfg_index == REG_REST))) |=> in_repeat_q)
		else $error("hold did not enter repeat phase");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_s1 && out_valid_q))
		else $error("input stalled with free pipeline");
`endif

endmodule

`default_nettype wire
